// ----- rtl/core/tcce_pkg.sv -----
`timescale 1ns / 1ps

package tcce_pkg;

  // op codes of an input transaction
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // control bytes understood by a put
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LINE_FEED = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;

  // grey on black space
  localparam logic [15:0] BLANK_CELL = 16'h0720;

  // command queue between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  char_code;
    logic [3:0]  bg_colour;
    logic [3:0]  fg_colour;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_location;
    logic [15:0] read_data;
    logic        scrolled;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_PRINT,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_RETURN,
    CMD_LINE_FEED,
    CMD_CLEAR,
    CMD_READ,
    CMD_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] cell_word;
    logic [10:0] index;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESULT
  } back_state_t;

endpackage

// ----- rtl/core/tcce_chan_if.sv -----
`timescale 1ns / 1ps

interface tcce_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/tcce_ram.sv -----
`timescale 1ns / 1ps

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/tcce_front.sv -----
`timescale 1ns / 1ps

module tcce_front import tcce_pkg::*; #(
  parameter int CELL_COUNT = 2000
) (
  input  logic  clk,
  input  logic  rst_n,
  tcce_chan_if.sink in_chan,
  output cmd_t  cmd_o,
  output logic  cmd_valid_o,
  input  logic  cmd_ready_i
);

  cmd_t     cmd_r, cmd_nxt;
  logic     valid_r;
  logic     take;
  in_item_t item;

  assign item         = in_chan.data;
  assign in_chan.ready = !valid_r || cmd_ready_i;
  assign take         = in_chan.valid && in_chan.ready;

  // classify the transaction into a back end command
  always_comb begin
    cmd_nxt           = '0;
    cmd_nxt.kind      = CMD_NONE;
    cmd_nxt.cell_word = {item.bg_colour, item.fg_colour, item.char_code};
    cmd_nxt.index     = item.cell_index;
    case (item.op)
      OP_PUT: begin
        if (item.char_code inside {[8'h20:8'h7F]}) begin
          cmd_nxt.kind = CMD_PRINT;
        end else begin
          case (item.char_code)
            CH_BACKSPACE: cmd_nxt.kind = CMD_BACKSPACE;
            CH_TAB:       cmd_nxt.kind = CMD_TAB;
            CH_RETURN:    cmd_nxt.kind = CMD_RETURN;
            CH_LINE_FEED: cmd_nxt.kind = CMD_LINE_FEED;
            default:      cmd_nxt.kind = CMD_NONE;
          endcase
        end
      end
      OP_CLEAR: cmd_nxt.kind = CMD_CLEAR;
      OP_READ: begin
        // out of range reads answer zero like an unused op
        if ({21'd0, item.cell_index} < 32'(CELL_COUNT)) begin
          cmd_nxt.kind = CMD_READ;
        end
      end
      default: cmd_nxt.kind = CMD_NONE;
    endcase
  end

  // holding register towards the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_o       = cmd_r;
  assign cmd_valid_o = valid_r;

endmodule

// ----- rtl/core/tcce_cmd_queue.sv -----
`timescale 1ns / 1ps

module tcce_cmd_queue import tcce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t push_cmd_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_cmd_o,
  output logic pop_valid_o,
  input  logic pop_i
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  cmd_t             q_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_r != CNT_W'(Q_DEPTH);
  assign pop_valid_o  = cnt_r != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_cmd_o    = q_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/core/tcce_back.sv -----
`timescale 1ns / 1ps

module tcce_back import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic pop_o,
  tcce_chan_if.source out_chan
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int CX         = $clog2(COLUMNS + 4);
  localparam int ROW_W      = $clog2(ROWS);

  back_state_t      st_r, st_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             rd_sel_r, rd_sel_nxt;
  logic             out_valid_r;
  out_item_t        out_r;
  logic             out_load;

  logic [CX-1:0]    colx;
  logic             row_step, wrap, scroll;
  logic [AW-1:0]    lin_cur;
  logic [CW-1:0]    cnt_dec, cnt_src;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [15:0]      wdata, rdata;

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lin_cur = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);
  assign cnt_dec = cnt_r - CW'(1);
  assign cnt_src = cnt_r + CW'(COLUMNS);
  assign pop_o   = (st_r == ST_IDLE) && cmd_valid_i;

  // cursor motion of the command at the queue head
  always_comb begin
    colx     = CX'(col_r);
    row_step = 1'b0;
    case (cmd_i.kind)
      CMD_PRINT:     colx = CX'(col_r) + CX'(1);
      CMD_BACKSPACE: colx = (col_r != '0) ? CX'(col_r) - CX'(1) : CX'(col_r);
      CMD_TAB:       colx = (CX'(col_r) + CX'(4)) & ~CX'(3);
      CMD_RETURN:    colx = '0;
      CMD_LINE_FEED: begin
        colx     = '0;
        row_step = 1'b1;
      end
      default:       colx = CX'(col_r);
    endcase
    wrap   = colx >= CX'(COLUMNS);
    scroll = (row_step || wrap) && (row_r == ROW_W'(ROWS - 1));
  end

  // sequencer: execute, scroll copy, clear sweep, result
  always_comb begin
    st_nxt       = st_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cnt_nxt      = cnt_r;
    scrolled_nxt = scrolled_r;
    rd_sel_nxt   = rd_sel_r;
    we           = 1'b0;
    waddr        = lin_cur;
    wdata        = cmd_i.cell_word;
    re           = 1'b0;
    raddr        = AW'(cmd_i.index);
    out_load     = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          scrolled_nxt = 1'b0;
          rd_sel_nxt   = 1'b0;
          cnt_nxt      = '0;
          st_nxt       = ST_RESULT;
          case (cmd_i.kind)
            CMD_CLEAR: begin
              col_nxt = '0;
              row_nxt = '0;
              st_nxt  = ST_CLEAR;
            end
            CMD_READ: begin
              re         = 1'b1;
              rd_sel_nxt = 1'b1;
            end
            default: begin
              we      = cmd_i.kind == CMD_PRINT;
              col_nxt = wrap ? '0 : COL_W'(colx);
              if ((row_step || wrap) && !scroll) begin
                row_nxt = row_r + 1'b1;
              end
              if (scroll) begin
                scrolled_nxt = 1'b1;
                st_nxt       = ST_SCROLL;
              end
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write back the cell read in the previous cycle
        re    = cnt_r < CW'(COPY_COUNT);
        raddr = cnt_src[AW-1:0];
        we    = cnt_r != '0;
        waddr = cnt_dec[AW-1:0];
        wdata = (cnt_r <= CW'(COPY_COUNT)) ? rdata : BLANK_CELL;
        if (cnt_r == CW'(CELL_COUNT)) begin
          st_nxt = ST_RESULT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        wdata = BLANK_CELL;
        if (cnt_r == CW'(CELL_COUNT - 1)) begin
          st_nxt = ST_RESULT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      cnt_r      <= '0;
      scrolled_r <= 1'b0;
      rd_sel_r   <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      cnt_r      <= cnt_nxt;
      scrolled_r <= scrolled_nxt;
      rd_sel_r   <= rd_sel_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.cursor_location <= 11'(lin_cur);
      out_r.read_data       <= rd_sel_r ? rdata : 16'd0;
      out_r.scrolled        <= scrolled_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(col_r) < COLUMNS) && (32'(row_r) < ROWS))
    else $error("cursor outside the screen");

  // the queue is drained only by an idle sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_o |-> (st_r == ST_IDLE))
    else $error("command taken while busy");

  // a scroll pass ends in the result state and flags the scroll
  a_scroll_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCROLL) |=> ((st_r == ST_SCROLL) || (st_r == ST_RESULT)) && scrolled_r)
    else $error("scroll pass left early");

  // the result is loaded only after the previous one has been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_chan.ready))
    else $error("pending result overwritten");

endmodule

// ----- rtl/core/text_console_char_engine.sv -----
`timescale 1ns / 1ps

// Character-cell text console of COLUMNS x ROWS cells held in one screen
// memory. Every transaction (put, clear, read) gives one result with the
// cursor position. A plain put or a read is done by the cell write (or
// registered memory read) followed by the result load. A put that
// scrolls copies the screen up one row: the single memory port pair moves
// one cell per cycle, then the last row is blanked in the same pass. A
// clear blanks the screen one cell per cycle. The front end and a
// two-entry command queue keep taking transactions while the back end is
// busy. No clearing pass runs after reset: cells read before they are
// written by a put, clear or scroll hold no defined value.
module text_console_char_engine import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic clk,
  input logic rst_n,
  tcce_chan_if.sink   in_chan,
  tcce_chan_if.source out_chan
);

  cmd_t front_cmd, head_cmd;
  logic front_valid, front_ready;
  logic head_valid, head_pop;

  // accept and classify
  tcce_front #(
    .CELL_COUNT (COLUMNS * ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  // decoupling queue
  tcce_cmd_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_cmd_i   (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_cmd_o    (head_cmd),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop)
  );

  // execute against the screen memory
  tcce_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (head_cmd),
    .cmd_valid_i (head_valid),
    .pop_o       (head_pop),
    .out_chan    (out_chan)
  );

endmodule
